>>> hdl/sip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_pkg
// Shared constants for the segment intersection point block.
// ----------------------------------------------------------------------------
package sip_pkg;

    // default coordinate width (Q16.8)
    localparam int COORD_WIDTH_DEF = 24;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

endpackage
`default_nettype wire

>>> hdl/segment_intersection_point.sv
// Pipeline: front stages, the queue, then back stages (two multiply stages,
// one divide stage per quotient bit, output register).
// Throughput: one word per cycle while m_tready is high, set by the fully
// pipelined divider.
// Reset: synchronous, active low; clears all valid bits and the queue.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_point
// Intersection of a probe segment with a wall segment in Q16.8 fixed point.
// ----------------------------------------------------------------------------
module segment_intersection_point #(
    parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // probe_start_x, probe_start_y, probe_end_x, probe_end_y,
    // wall_start_x, wall_start_y, wall_end_x, wall_end_y
    input  wire logic [((8*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // hit_x, hit_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]          m_tdata,
    // hit
    output logic                                        m_tuser
);
    import sip_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int OUT_W = ((2 * W + 7) / 8) * 8;
    localparam int EW    = 1 + 2 * W + 2 * (W + 1) + 2 * (2 * W + 3);

    logic          f_valid, f_ready, b_valid, b_ready;
    logic [EW-1:0] f_entry, b_entry;
    logic          hit;
    logic [W-1:0]  hx, hy;

    // front: differences, cross products, range tests
    sip_front #(
        .COORD_WIDTH(W),
        .ENTRY_WIDTH(EW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata[8*W-1:0]),
        .out_valid(f_valid),
        .out_ready(f_ready),
        .out_entry(f_entry)
    );

    // decoupling queue
    sip_queue #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  (f_entry),
        .out_valid(b_valid),
        .out_ready(b_ready),
        .out_data (b_entry)
    );

    // back: point computation
    sip_back #(
        .COORD_WIDTH(W),
        .ENTRY_WIDTH(EW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (b_valid),
        .in_ready (b_ready),
        .in_entry (b_entry),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_hit  (hit),
        .out_x    (hx),
        .out_y    (hy)
    );

    assign m_tdata = OUT_W'({hy, hx});
    assign m_tuser = hit;

    // a miss carries a zero point
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss word with nonzero point");

    // nothing leaves the block right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

>>> hdl/sip_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_front
// Accepts segment pairs, forms cross products and classifies hit or miss.
// ----------------------------------------------------------------------------
module sip_front #(
    parameter int COORD_WIDTH = 24,
    parameter int ENTRY_WIDTH = 1 + 2 * 24 + 2 * 25 + 2 * 51
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [8*COORD_WIDTH-1:0]   in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [ENTRY_WIDTH-1:0]          out_entry
);
    localparam int W  = COORD_WIDTH;
    localparam int TW = 2 * W + 3;

    logic signed [W-1:0] p1x, p1y, p2x, p2y, ax, ay, bx, by;

    // stage 1: differences
    logic                v1_reg;
    logic signed [W-1:0] p1x1_reg, p1y1_reg;
    logic signed [W:0]   pdx1_reg, pdy1_reg, ldx1_reg, ldy1_reg, ox1_reg, oy1_reg;

    // stage 2: products
    logic                  v2_reg;
    logic signed [W-1:0]   p1x2_reg, p1y2_reg;
    logic signed [W:0]     pdx2_reg, pdy2_reg;
    logic signed [2*W+1:0] m_cpa_reg, m_cpb_reg, m_sa_reg, m_sb_reg, m_ta_reg, m_tb_reg;

    // stage 3: classification
    logic                v3_reg;
    logic [ENTRY_WIDTH-1:0] entry_reg;

    logic signed [TW-1:0] cp_next, sn_next, tn_next;
    logic                 s_in, t_in, hit_next;
    logic                 adv;

    assign {by, bx, ay, ax, p2y, p2x, p1y, p1x} = in_data;

    // whole front moves together unless the queue refuses the last word
    assign adv      = !v3_reg || out_ready;
    assign in_ready = adv;

    // numerators and denominator, sign extended one bit
    always_comb begin
        cp_next = {m_cpa_reg[2*W+1], m_cpa_reg} - {m_cpb_reg[2*W+1], m_cpb_reg};
        sn_next = {m_sa_reg[2*W+1], m_sa_reg} - {m_sb_reg[2*W+1], m_sb_reg};
        tn_next = {m_ta_reg[2*W+1], m_ta_reg} - {m_tb_reg[2*W+1], m_tb_reg};
        if (!cp_next[TW-1]) begin
            s_in = !sn_next[TW-1] && (sn_next <= cp_next);
            t_in = !tn_next[TW-1] && (tn_next <= cp_next);
        end else begin
            s_in = (cp_next <= sn_next) && (sn_next <= 0);
            t_in = (cp_next <= tn_next) && (tn_next <= 0);
        end
        hit_next = (cp_next != 0) && s_in && t_in;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1x1_reg <= p1x;
            p1y1_reg <= p1y;
            pdx1_reg <= {p2x[W-1], p2x} - {p1x[W-1], p1x};
            pdy1_reg <= {p2y[W-1], p2y} - {p1y[W-1], p1y};
            ldx1_reg <= {bx[W-1], bx} - {ax[W-1], ax};
            ldy1_reg <= {by[W-1], by} - {ay[W-1], ay};
            ox1_reg  <= {p1x[W-1], p1x} - {ax[W-1], ax};
            oy1_reg  <= {p1y[W-1], p1y} - {ay[W-1], ay};

            p1x2_reg  <= p1x1_reg;
            p1y2_reg  <= p1y1_reg;
            pdx2_reg  <= pdx1_reg;
            pdy2_reg  <= pdy1_reg;
            m_cpa_reg <= pdx1_reg * ldy1_reg;
            m_cpb_reg <= pdy1_reg * ldx1_reg;
            m_sa_reg  <= pdx1_reg * oy1_reg;
            m_sb_reg  <= pdy1_reg * ox1_reg;
            m_ta_reg  <= ldx1_reg * oy1_reg;
            m_tb_reg  <= ldy1_reg * ox1_reg;

            entry_reg <= {hit_next, p1x2_reg, p1y2_reg, pdx2_reg, pdy2_reg,
                          tn_next, cp_next};
        end
    end

    assign out_valid = v3_reg;
    assign out_entry = entry_reg;

endmodule
`default_nettype wire

>>> hdl/sip_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_queue
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module sip_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

>>> hdl/sip_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sip_back
// Forms t*pd over split products, divides by cp one bit a stage, adds P1.
// ----------------------------------------------------------------------------
module sip_back #(
    parameter int COORD_WIDTH = 24,
    parameter int ENTRY_WIDTH = 1 + 2 * 24 + 2 * 25 + 2 * 51
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [ENTRY_WIDTH-1:0] in_entry,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        out_hit,
    output logic [COORD_WIDTH-1:0]      out_x,
    output logic [COORD_WIDTH-1:0]      out_y
);
    localparam int W  = COORD_WIDTH;
    localparam int TW = 2 * W + 3;
    localparam int TL = (TW + 1) / 2;
    localparam int TH = TW - TL;
    localparam int NW = 3 * W + 4;

    logic          e_hit;
    logic [W-1:0]  e_p1x, e_p1y;
    logic [W:0]    e_pdx, e_pdy;
    logic [TW-1:0] e_tn, e_cp;

    logic [TW-1:0] atn, acp;
    logic [W:0]    apdx, apdy;
    logic          adv;

    // stage b1: partial products
    logic              v1_reg, hit1_reg, nx1_reg, ny1_reg;
    logic [W-1:0]      p1x1_reg, p1y1_reg;
    logic [TW-1:0]     d1_reg;
    logic [TL+W:0]     plx_reg, ply_reg;
    logic [TH+W:0]     phx_reg, phy_reg;

    // divide stages, index 0 holds the dividend
    logic          vd_reg  [0:W+1];
    logic          hitd_reg[0:W+1];
    logic          nxd_reg [0:W+1];
    logic          nyd_reg [0:W+1];
    logic [W-1:0]  p1xd_reg[0:W+1];
    logic [W-1:0]  p1yd_reg[0:W+1];
    logic [NW-1:0] dd_reg  [0:W+1];
    logic [NW-1:0] rx_reg  [0:W+1];
    logic [NW-1:0] ry_reg  [0:W+1];
    logic [W:0]    qx_reg  [0:W+1];
    logic [W:0]    qy_reg  [0:W+1];

    // output register
    logic          vo_reg, hito_reg;
    logic [W-1:0]  xo_reg, yo_reg;
    logic [W+1:0]  sqx_next, sqy_next;
    logic [W+1:0]  hx_next, hy_next;

    assign {e_hit, e_p1x, e_p1y, e_pdx, e_pdy, e_tn, e_cp} = in_entry;

    // whole back moves together, stalled only by the output register
    assign adv      = !vo_reg || out_ready;
    assign in_ready = adv;

    // magnitudes
    assign atn  = e_tn[TW-1]  ? (~e_tn + 1'b1)  : e_tn;
    assign acp  = e_cp[TW-1]  ? (~e_cp + 1'b1)  : e_cp;
    assign apdx = e_pdx[W]    ? (~e_pdx + 1'b1) : e_pdx;
    assign apdy = e_pdy[W]    ? (~e_pdy + 1'b1) : e_pdy;

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            for (int i = 0; i <= W + 1; i++) begin
                vd_reg[i] <= 1'b0;
            end
            vo_reg <= 1'b0;
        end else if (adv) begin
            v1_reg    <= in_valid;
            vd_reg[0] <= v1_reg;
            for (int i = 0; i <= W; i++) begin
                vd_reg[i+1] <= vd_reg[i];
            end
            vo_reg <= vd_reg[W+1];
        end
    end

    // split multiply and dividend assembly
    always_ff @(posedge aclk) begin
        if (adv) begin
            hit1_reg <= e_hit;
            nx1_reg  <= e_tn[TW-1] ^ e_pdx[W] ^ e_cp[TW-1];
            ny1_reg  <= e_tn[TW-1] ^ e_pdy[W] ^ e_cp[TW-1];
            p1x1_reg <= e_p1x;
            p1y1_reg <= e_p1y;
            d1_reg   <= acp;
            plx_reg  <= atn[TL-1:0]  * apdx;
            phx_reg  <= atn[TW-1:TL] * apdx;
            ply_reg  <= atn[TL-1:0]  * apdy;
            phy_reg  <= atn[TW-1:TL] * apdy;

            hitd_reg[0] <= hit1_reg;
            nxd_reg[0]  <= nx1_reg;
            nyd_reg[0]  <= ny1_reg;
            p1xd_reg[0] <= p1x1_reg;
            p1yd_reg[0] <= p1y1_reg;
            dd_reg[0]   <= NW'(d1_reg);
            rx_reg[0]   <= NW'(plx_reg) + (NW'(phx_reg) << TL);
            ry_reg[0]   <= NW'(ply_reg) + (NW'(phy_reg) << TL);
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
        end
    end

    // restoring divide, quotient bit W-i at stage i
    for (genvar i = 0; i <= W; i++) begin : g_div
        localparam int K = W - i;
        logic [NW-1:0] dsh;
        logic          gex, gey;

        assign dsh = dd_reg[i] << K;
        assign gex = (rx_reg[i] >= dsh);
        assign gey = (ry_reg[i] >= dsh);

        always_ff @(posedge aclk) begin
            if (adv) begin
                hitd_reg[i+1] <= hitd_reg[i];
                nxd_reg[i+1]  <= nxd_reg[i];
                nyd_reg[i+1]  <= nyd_reg[i];
                p1xd_reg[i+1] <= p1xd_reg[i];
                p1yd_reg[i+1] <= p1yd_reg[i];
                dd_reg[i+1]   <= dd_reg[i];
                rx_reg[i+1]   <= gex ? (rx_reg[i] - dsh) : rx_reg[i];
                ry_reg[i+1]   <= gey ? (ry_reg[i] - dsh) : ry_reg[i];
                qx_reg[i+1]   <= {qx_reg[i][W-1:0], gex};
                qy_reg[i+1]   <= {qy_reg[i][W-1:0], gey};
            end
        end
    end

    // sign of quotient and offset from P1
    always_comb begin
        sqx_next = nxd_reg[W+1] ? (~{1'b0, qx_reg[W+1]} + 1'b1) : {1'b0, qx_reg[W+1]};
        sqy_next = nyd_reg[W+1] ? (~{1'b0, qy_reg[W+1]} + 1'b1) : {1'b0, qy_reg[W+1]};
        hx_next  = {{2{p1xd_reg[W+1][W-1]}}, p1xd_reg[W+1]} + sqx_next;
        hy_next  = {{2{p1yd_reg[W+1][W-1]}}, p1yd_reg[W+1]} + sqy_next;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hito_reg <= hitd_reg[W+1];
            xo_reg   <= hitd_reg[W+1] ? hx_next[W-1:0] : '0;
            yo_reg   <= hitd_reg[W+1] ? hy_next[W-1:0] : '0;
        end
    end

    assign out_valid = vo_reg;
    assign out_hit   = hito_reg;
    assign out_x     = xo_reg;
    assign out_y     = yo_reg;

endmodule
`default_nettype wire

>>> dv/tb_segment_intersection_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_point
// Drives probe/wall segment pairs into the block and compares hit flag and
// intersection point against an exact integer predictor, with random gaps
// on both sides and one long output stall.
// ----------------------------------------------------------------------------

// exact intersection predictor and queue of expected results
class hit_scoreboard;
    typedef struct packed {
        logic        hit;
        logic [23:0] hx;
        logic [23:0] hy;
    } hit_result_t;

    hit_result_t pending[$];
    int          errors;
    int          hits;
    int          checked;

    // work out the expected result of one pair of segments
    function automatic hit_result_t compute_hit(logic [191:0] word);
        logic signed [127:0] c[8];
        logic signed [127:0] pdx, pdy, ldx, ldy, ox, oy, cp, sn, tn;
        hit_result_t r;
        bit s_ok, t_ok;
        for (int i = 0; i < 8; i++) begin
            c[i] = 128'(signed'(word[i*24 +: 24]));
        end
        r = '0;
        pdx = c[2] - c[0];
        pdy = c[3] - c[1];
        ldx = c[6] - c[4];
        ldy = c[7] - c[5];
        ox = c[0] - c[4];
        oy = c[1] - c[5];
        cp = pdx * ldy - pdy * ldx;
        if (cp == 0) return r;
        sn = pdx * oy - pdy * ox;
        tn = ldx * oy - ldy * ox;
        if (cp > 0) begin
            s_ok = sn >= 0 && sn <= cp;
            t_ok = tn >= 0 && tn <= cp;
        end else begin
            s_ok = sn <= 0 && sn >= cp;
            t_ok = tn <= 0 && tn >= cp;
        end
        if (!(s_ok && t_ok)) return r;
        // verilog signed division truncates toward zero
        r.hit = 1'b1;
        r.hx = 24'(c[0] + (tn * pdx) / cp);
        r.hy = 24'(c[1] + (tn * pdy) / cp);
        return r;
    endfunction

    function void note_input(logic [191:0] word);
        hit_result_t r;
        r = compute_hit(word);
        pending.push_back(r);
        if (r.hit) hits++;
    endfunction

    function void check_result(logic hit, logic [47:0] data);
        hit_result_t e;
        if (pending.size() == 0) begin
            $error("unexpected result word: hit=%0b data=%h", hit, data);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (hit !== e.hit) begin
            $error("hit mismatch: expected %0b actual %0b", e.hit, hit);
            errors++;
        end
        if (data[23:0] !== e.hx) begin
            $error("hit_x mismatch: expected %h actual %h", e.hx, data[23:0]);
            errors++;
        end
        if (data[47:24] !== e.hy) begin
            $error("hit_y mismatch: expected %h actual %h", e.hy, data[47:24]);
            errors++;
        end
    endfunction
endclass

module tb_segment_intersection_point;
    localparam int RANDOM_WORDS = 1830;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_LEN    = 300;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic         m_tuser;

    hit_scoreboard sb = new();
    int  cycles = 0;
    bit  long_stall = 1'b0;
    int  accepted = 0;

    segment_intersection_point dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    // cycle counter and timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // sample both handshakes at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_input(s_tdata);
            accepted <= accepted + 1;
        end
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    // offer one word and wait for it to be taken
    task automatic send_word(logic [191:0] word, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [191:0] pack_pair(int v[8]);
        logic [191:0] w;
        for (int i = 0; i < 8; i++) w[i*24 +: 24] = 24'(v[i]);
        return w;
    endfunction

    function automatic int rnd_coord(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // mostly crossing pairs around a random center, some fully random
    function automatic logic [191:0] random_pair();
        logic [191:0] w;
        int v[8];
        int span, cx, cy, k;
        k = $urandom_range(0, 9);
        if (k < 2) begin
            w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return w;
        end
        span = (k < 5) ? 256 << $urandom_range(0, 14) : 2048;
        cx = rnd_coord(4000000);
        cy = rnd_coord(4000000);
        for (int i = 0; i < 8; i++) v[i] = ((i % 2) ? cy : cx) + rnd_coord(span);
        // force a shared endpoint or a parallel wall now and then
        if (k == 9) begin
            v[4] = v[2];
            v[5] = v[3];
        end else if (k == 8) begin
            v[6] = v[4] + (v[2] - v[0]);
            v[7] = v[5] + (v[3] - v[1]);
        end
        return pack_pair(v);
    endfunction

    // receiver: random stalls, one long hold-off in the middle
    initial begin
        int gap;
        bit stalled;
        stalled = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_stall && !stalled) begin
                m_tready <= 1'b0;
                repeat (STALL_LEN) @(negedge aclk);
                stalled = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // stimulus and end of run
    initial begin
        localparam int MAXC = 8388607;
        localparam int MINC = -8388608;
        int d[8];
        int wait_cycles;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // simple crossing, endpoint touches, parallel, collinear, degenerate
        d = '{0, 0, 512, 512, 0, 512, 512, 0};           send_word(pack_pair(d), 0);
        d = '{0, 0, 256, 0, 256, -256, 256, 256};        send_word(pack_pair(d), 0);
        d = '{0, 0, 256, 0, 0, -256, 0, 256};            send_word(pack_pair(d), 0);
        d = '{0, 0, 256, 256, 256, 256, 512, 0};         send_word(pack_pair(d), 0);
        d = '{0, 0, 256, 0, 0, 256, 256, 256};           send_word(pack_pair(d), 0);
        d = '{0, 0, 512, 0, 256, 0, 768, 0};             send_word(pack_pair(d), 0);
        d = '{5, 5, 5, 5, 0, 0, 256, 256};               send_word(pack_pair(d), 0);
        d = '{0, 0, 256, 256, 7, 7, 7, 7};               send_word(pack_pair(d), 0);
        d = '{0, 0, 256, 0, 512, -256, 512, 256};        send_word(pack_pair(d), 0);
        d = '{0, 0, 256, 256, 0, 7, 256, 263};           send_word(pack_pair(d), 0);
        // extremes of the coordinate range
        d = '{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC};
        send_word(pack_pair(d), 0);
        d = '{MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC};
        send_word(pack_pair(d), 0);
        d = '{MINC, 0, MAXC, 0, 0, MINC, 0, MAXC};       send_word(pack_pair(d), 0);
        d = '{MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC};
        send_word(pack_pair(d), 0);
        d = '{-3, -1, 3, 2, -2, 1, 1, -2};               send_word(pack_pair(d), 0);
        d = '{-1, -1, -1, -1, -1, -1, -1, -1};           send_word(pack_pair(d), 0);
        d = '{MINC, MINC, MINC, MAXC, MINC, MINC, MAXC, MINC};
        send_word(pack_pair(d), 0);

        // random part; back to back bursts, one long receiver hold-off
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) long_stall = 1'b1;
            send_word(random_pair(), (n % 200) < 40);
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (64) @(posedge aclk);

        $display("covered %0d segment pairs, %0d results checked, %0d hits",
                 accepted, sb.checked, sb.hits);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
hdl/sip_pkg.sv
hdl/sip_front.sv
hdl/sip_queue.sv
hdl/sip_back.sv
hdl/segment_intersection_point.sv
dv/tb_segment_intersection_point.sv
